### design/sfce_pkg.sv
// ----------------------------------------------------------------------------
// sfce_pkg
// Shared types, codes, access table and CRC-8 helper for the register
// frame engine.
// ----------------------------------------------------------------------------
package sfce_pkg;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] device_id;
      logic [7:0] reg_index;
      logic [7:0] value;
      logic [7:0] count;
      logic       check_crc;
      logic       link_error;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_byte;
      logic [1:0]  status;
      logic [15:0] err_count;
      logic [7:0]  err_flags;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       read_pending;
      logic [5:0] pending_device;
      logic [8:0] bytes_left;
      logic [7:0] running_crc;
      logic       pending_check;
   } state_type;

   typedef struct packed {
      logic none;
      logic start_read;
      logic check_upd;
   } ctl_type;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_RECV   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] KIND_TX   = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_ACCESS = 2'd1;
   localparam logic [1:0] ST_LINK_ERR  = 2'd2;
   localparam logic [1:0] ST_CRC_ERR   = 2'd3;

   localparam logic [1:0] ACC_READ  = 2'h1;
   localparam logic [1:0] ACC_WRITE = 2'h2;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam int TABLE_SIZE = 80;

   localparam logic [1:0] ACCESS_TABLE [0:TABLE_SIZE-1] = '{
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
      2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
      2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
      2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0,
      2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0,
      2'd0, 2'd0, 2'd3, 2'd3, 2'd2, 2'd3, 2'd0, 2'd3,
      2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3,
      2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0
   };

   function automatic logic [1:0] access_of(input logic [7:0] reg_index);
      logic [1:0] acc;
      acc = 2'd0;
      if (reg_index < 8'(TABLE_SIZE)) begin
         acc = ACCESS_TABLE[reg_index[6:0]];
      end
      return acc;
   endfunction

   // MSB first, no final xor
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

### design/spi_register_frame_crc8_engine.sv
// ----------------------------------------------------------------------------
// spi_register_frame_crc8_engine
// Host-side register framing with CRC-8 (poly 0x07) for a daisy-chained
// cell monitor, including read-back CRC checking and error counters.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per request or received byte, valid/ready.
//   rsp_*  : result items (transmit byte, read data byte, done), valid/ready;
//            rsp_data.last marks the final result of each request item.
//   An accepted item sits in the input register; its results are produced
//   one per cycle into the output register while it is free or rsp_ready
//   is high. Results per item: write 5, granted read request 3, unchecked
//   final read byte 2, anything else 1, ignored items none. The output
//   register sets the pace, one result per cycle unless rsp_ready is low.
//   A new item is taken in the cycle its last result is registered, so
//   items follow back to back.
//   When rsp_ready is low the output register holds, the item in the input
//   register waits and req_ready drops once that register is occupied.
//   Reset clears the pending read, the error flags and the counters.
// ----------------------------------------------------------------------------
module spi_register_frame_crc8_engine
   import sfce_pkg::*;
#(
   parameter int NUM_DEVICES = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type    in_ff;
   logic       in_valid_ff;
   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   state_type  state_ff;
   state_type  state_in;
   rsp_type    rsp_ff;
   logic       rsp_valid_ff;

   rsp_type     res;
   ctl_type     ctl;
   logic        out_load;
   logic        item_done;
   logic [7:0]  flags;
   logic [15:0] new_count;
   logic [7:0]  new_flags;

   assign out_load  = in_valid_ff && !ctl.none && (!rsp_valid_ff || rsp_ready);
   assign item_done = in_valid_ff && (ctl.none || (out_load && res.last));
   assign req_ready = !in_valid_ff || item_done;

   sfce_codec u_codec (
      .item      (in_ff),
      .idx       (idx_ff),
      .state     (state_ff),
      .flags     (flags),
      .new_count (new_count),
      .new_flags (new_flags),
      .res       (res),
      .ctl       (ctl),
      .state_in  (state_in)
   );

   sfce_err_bank #(
      .NUM_DEVICES (NUM_DEVICES)
   ) u_err_bank (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (item_done && ctl.start_read),
      .rd_dev    (in_ff.device_id),
      .upd_en    (item_done && ctl.check_upd),
      .upd_dev   (state_ff.pending_device),
      .upd_ok    (in_ff.value == state_ff.running_crc),
      .new_count (new_count),
      .new_flags (new_flags),
      .flags     (flags)
   );

   always_comb begin
      idx_in = idx_ff;
      if (item_done) begin
         idx_in = 3'd0;
      end else if (out_load) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         idx_ff       <= 3'd0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (item_done) begin
            state_ff <= state_in;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (out_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (idx_ff <= 3'd4))
      else $error("result position out of range");

   a_pending_bytes: assert property (@(posedge clock) disable iff (reset)
      state_ff.read_pending |-> (state_ff.bytes_left != 9'd0))
      else $error("pending read with no bytes left");

   a_last_rewinds: assert property (@(posedge clock) disable iff (reset)
      (out_load && res.last) |=> (idx_ff == 3'd0))
      else $error("position not cleared after last result");

   a_read_arms: assert property (@(posedge clock) disable iff (reset)
      (item_done && ctl.start_read) |=> state_ff.read_pending)
      else $error("granted read did not arm pending read");
`endif

endmodule

### design/sfce_ram.sv
// ----------------------------------------------------------------------------
// sfce_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sfce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/sfce_err_bank.sv
// ----------------------------------------------------------------------------
// sfce_err_bank
// Per-device CRC error counters (RAM plus written bits) and the error flag
// register, with the saturating update computed ahead of commit.
// ----------------------------------------------------------------------------
module sfce_err_bank #(
   parameter int NUM_DEVICES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        rd_en,
   input  logic [5:0]  rd_dev,
   input  logic        upd_en,
   input  logic [5:0]  upd_dev,
   input  logic        upd_ok,
   output logic [15:0] new_count,
   output logic [7:0]  new_flags,
   output logic [7:0]  flags
);

   localparam int IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
   localparam logic [5:0] NDEV = 6'(NUM_DEVICES);

   logic [NUM_DEVICES-1:0] written_ff;
   logic [NUM_DEVICES-1:0] written_in;
   logic [7:0]             flags_ff;
   logic [5:0]             rd_m1;
   logic [5:0]             upd_m1;
   logic [IDX_W-1:0]       upd_idx;
   logic                   in_range;
   logic [15:0]            ram_q;
   logic [15:0]            cur_count;
   logic                   wr_en;

   assign rd_m1    = rd_dev - 6'd1;
   assign upd_m1   = upd_dev - 6'd1;
   assign upd_idx  = upd_m1[IDX_W-1:0];
   assign in_range = (upd_dev != 6'd0) && (upd_dev <= NDEV);
   assign wr_en    = upd_en && in_range;

   sfce_ram #(
      .WIDTH (16),
      .DEPTH (NUM_DEVICES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (upd_idx),
      .wr_data (new_count),
      .rd_en   (rd_en),
      .rd_addr (rd_m1[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   // unwritten entries read as zero
   assign cur_count = written_ff[upd_idx] ? ram_q : 16'd0;

   always_comb begin
      new_count = 16'd0;
      new_flags = flags_ff;
      if (in_range) begin
         if (upd_ok) begin
            new_count = 16'd0;
         end else if (cur_count == 16'hFFFF) begin
            new_count = cur_count;
         end else begin
            new_count = cur_count + 16'd1;
         end
         if (upd_m1 < 6'd8) begin
            new_flags[upd_m1[2:0]] = !upd_ok;
         end
      end
   end

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[upd_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         flags_ff   <= 8'd0;
      end else begin
         written_ff <= written_in;
         if (upd_en) begin
            flags_ff <= new_flags;
         end
      end
   end

   assign flags = flags_ff;

`ifndef ASSERT_OFF
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !upd_en |=> $stable(flags_ff))
      else $error("flags changed without a CRC check");
`endif

endmodule

### design/sfce_codec.sv
// ----------------------------------------------------------------------------
// sfce_codec
// Builds the result at a given position for the held item and works out
// the pending-read state that the item leaves behind.
// ----------------------------------------------------------------------------
module sfce_codec
   import sfce_pkg::*;
(
   input  req_type     item,
   input  logic [2:0]  idx,
   input  state_type   state,
   input  logic [7:0]  flags,
   input  logic [15:0] new_count,
   input  logic [7:0]  new_flags,
   output rsp_type     res,
   output ctl_type     ctl,
   output state_type   state_in
);

   logic       is_write;
   logic       grant;
   logic [7:0] b0;
   logic [7:0] b2;
   logic [7:0] crc_req;
   logic       crc_ok;

   assign is_write = (item.cmd == CMD_WRITE);
   assign grant    = (access_of(item.reg_index) & (is_write ? ACC_WRITE : ACC_READ)) != 2'd0;
   assign b0       = {1'b0, item.device_id, is_write};
   assign b2       = is_write ? item.value : item.count;
   assign crc_req  = crc8_byte(crc8_byte(crc8_byte(8'd0, b0), item.reg_index), b2);
   assign crc_ok   = (item.value == state.running_crc);

   always_comb begin
      res      = '0;
      ctl      = '0;
      state_in = state;
      unique case (item.cmd) inside
         CMD_WRITE, CMD_READ: begin
            state_in.read_pending = 1'b0;
            if (!grant) begin
               res.kind      = KIND_DONE;
               res.status    = ST_NO_ACCESS;
               res.err_flags = flags;
               res.last      = 1'b1;
            end else begin
               res.kind = KIND_TX;
               case (idx)
                  3'd0: res.out_byte = b0;
                  3'd1: res.out_byte = item.reg_index;
                  3'd2: begin
                     res.out_byte = b2;
                     res.last     = !is_write;
                  end
                  3'd3: res.out_byte = crc_req;
                  default: begin
                     res.kind      = KIND_DONE;
                     res.err_flags = flags;
                     res.last      = 1'b1;
                  end
               endcase
               if (!is_write) begin
                  ctl.start_read         = 1'b1;
                  state_in.read_pending   = 1'b1;
                  state_in.pending_device = item.device_id;
                  state_in.bytes_left     = 9'(item.count) + 9'd1;
                  state_in.running_crc    = crc_req;
                  state_in.pending_check  = item.check_crc;
               end
            end
         end
         CMD_RECV: begin
            if (!state.read_pending) begin
               ctl.none = 1'b1;
            end else if (item.link_error) begin
               state_in.read_pending = 1'b0;
               state_in.bytes_left   = 9'd0;
               res.kind      = KIND_DONE;
               res.status    = ST_LINK_ERR;
               res.err_flags = flags;
               res.last      = 1'b1;
            end else if (state.bytes_left > 9'd1) begin
               state_in.running_crc = crc8_byte(state.running_crc, item.value);
               state_in.bytes_left  = state.bytes_left - 9'd1;
               res.kind     = KIND_DATA;
               res.out_byte = item.value;
               res.last     = 1'b1;
            end else begin
               state_in.read_pending = 1'b0;
               state_in.bytes_left   = 9'd0;
               if (!state.pending_check) begin
                  if (idx == 3'd0) begin
                     res.kind     = KIND_DATA;
                     res.out_byte = item.value;
                  end else begin
                     res.kind      = KIND_DONE;
                     res.err_flags = flags;
                     res.last      = 1'b1;
                  end
               end else begin
                  ctl.check_upd = 1'b1;
                  res.kind      = KIND_DONE;
                  res.status    = crc_ok ? ST_OK : ST_CRC_ERR;
                  res.err_count = new_count;
                  res.err_flags = new_flags;
                  res.last      = 1'b1;
               end
            end
         end
         default: begin
            ctl.none = 1'b1;
         end
      endcase
   end

endmodule
